### hdl/pwc_pkg.sv
// Power window controller package: item types, mode encoding, drive codes
// and configuration register indexes. No dependencies.
package pwc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_TICKS = 2'd1;

    localparam logic [CFG_DATA_W-1:0] REG_RESET = 16'd500;

    localparam logic [1:0] DRIVE_STOP = 2'd0;
    localparam logic [1:0] DRIVE_UP   = 2'd1;
    localparam logic [1:0] DRIVE_DOWN = 2'd2;

    typedef enum logic [7:0] {
        M_IDLE        = 8'b0000_0001,
        M_UP_WAIT     = 8'b0000_0010,
        M_DOWN_WAIT   = 8'b0000_0100,
        M_UP_MANUAL   = 8'b0000_1000,
        M_DOWN_MANUAL = 8'b0001_0000,
        M_UP_AUTO     = 8'b0010_0000,
        M_DOWN_AUTO   = 8'b0100_0000,
        M_REVERSE     = 8'b1000_0000
    } t_mode;

    typedef struct packed {
        logic power_press;
        logic lock_press;
        logic driver_up;
        logic driver_down;
        logic passenger_up;
        logic passenger_down;
        logic top_limit;
        logic bottom_limit;
        logic jam_event;
    } t_in_item;

    typedef struct packed {
        logic [1:0] motor_drive;
        logic       red_lamp;
        logic       blue_lamp;
        logic       powered;
        logic       locked;
    } t_out_item;

    typedef struct packed {
        logic [TICK_W-1:0] hold_ticks;
        logic [TICK_W-1:0] reverse_ticks;
    } t_cfg;

endpackage

### hdl/pwc_cfg.sv
// Configuration registers for hold and reverse times.
// Depends on pwc_pkg.
module pwc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pwc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pwc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output pwc_pkg::t_cfg                    o_cfg
);
    import pwc_pkg::*;

    logic [TICK_W-1:0] r_hold;
    logic [TICK_W-1:0] r_reverse;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold    <= REG_RESET;
            r_reverse <= REG_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_HOLD_TICKS) begin
                r_hold <= i_cfg_data;
            end
            if (i_cfg_index == REG_REVERSE_TICKS) begin
                r_reverse <= i_cfg_data;
            end
        end
    end

    assign o_cfg.hold_ticks    = r_hold;
    assign o_cfg.reverse_ticks = r_reverse;

endmodule

### hdl/pwc_fsm.sv
// Window mode state machine with tick counter and power/lock flags.
// Computes one result per enabled cycle. Depends on pwc_pkg.
module pwc_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  pwc_pkg::t_in_item  i_item,
    input  pwc_pkg::t_cfg      i_cfg,
    output pwc_pkg::t_out_item o_result
);
    import pwc_pkg::*;

    t_mode             r_mode;
    t_mode             n_mode;
    t_mode             m_cur;
    logic [TICK_W-1:0] r_cnt;
    logic [TICK_W-1:0] n_cnt;
    logic [TICK_W-1:0] c_inc;
    logic              r_power;
    logic              n_power;
    logic              r_lock;
    logic              n_lock;
    logic              up_req;
    logic              down_req;
    logic [1:0]        drive;

    function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
        return (v == {TICK_W{1'b1}}) ? v : v + {{(TICK_W-1){1'b0}}, 1'b1};
    endfunction

    always_comb begin
        n_power  = r_power ^ i_item.power_press;
        n_lock   = r_lock;
        n_mode   = r_mode;
        n_cnt    = r_cnt;
        drive    = DRIVE_STOP;
        up_req   = 1'b0;
        down_req = 1'b0;
        c_inc    = '0;
        if (i_item.power_press && !n_power) begin
            n_mode = M_IDLE;
            n_cnt  = '0;
        end
        if (n_power && i_item.lock_press) begin
            n_lock = !r_lock;
        end
        m_cur = n_mode;
        if (n_power) begin
            up_req   = i_item.driver_up   | (i_item.passenger_up   & ~n_lock);
            down_req = i_item.driver_down | (i_item.passenger_down & ~n_lock);
            case (m_cur)
                M_IDLE: begin
                    if (up_req) begin
                        n_mode = M_UP_WAIT;
                        n_cnt  = '0;
                    end else if (down_req) begin
                        n_mode = M_DOWN_WAIT;
                        n_cnt  = '0;
                    end
                end
                M_UP_WAIT: begin
                    if (i_item.jam_event) begin
                        n_mode = M_REVERSE;
                        n_cnt  = '0;
                    end else begin
                        c_inc = sat_inc(r_cnt);
                        n_cnt = c_inc;
                        if (c_inc >= i_cfg.hold_ticks) begin
                            n_mode = up_req ? M_UP_MANUAL : M_UP_AUTO;
                        end
                    end
                end
                M_DOWN_WAIT: begin
                    c_inc = sat_inc(r_cnt);
                    n_cnt = c_inc;
                    if (c_inc >= i_cfg.hold_ticks) begin
                        n_mode = down_req ? M_DOWN_MANUAL : M_DOWN_AUTO;
                    end
                end
                M_UP_MANUAL: begin
                    if (i_item.jam_event) begin
                        n_mode = M_REVERSE;
                        n_cnt  = '0;
                    end else if (!up_req) begin
                        n_mode = M_IDLE;
                    end
                end
                M_UP_AUTO: begin
                    if (i_item.jam_event) begin
                        n_mode = M_REVERSE;
                        n_cnt  = '0;
                    end else if (i_item.top_limit || down_req) begin
                        n_mode = M_IDLE;
                    end
                end
                M_DOWN_MANUAL: begin
                    if (!down_req) begin
                        n_mode = M_IDLE;
                    end
                end
                M_DOWN_AUTO: begin
                    if (i_item.bottom_limit || up_req) begin
                        n_mode = M_IDLE;
                    end
                end
                M_REVERSE: begin
                    if (r_cnt >= i_cfg.reverse_ticks) begin
                        n_mode = M_IDLE;
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                end
            endcase

            case (n_mode)
                M_UP_MANUAL, M_UP_AUTO: begin
                    if (!i_item.top_limit) begin
                        drive = DRIVE_UP;
                    end
                end
                M_DOWN_MANUAL, M_DOWN_AUTO: begin
                    if (!i_item.bottom_limit) begin
                        drive = DRIVE_DOWN;
                    end
                end
                M_REVERSE: begin
                    drive = DRIVE_DOWN;
                    n_cnt = sat_inc(n_cnt);
                end
                default: begin
                    drive = DRIVE_STOP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_cnt   <= '0;
            r_power <= 1'b0;
            r_lock  <= 1'b0;
        end else if (i_en) begin
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
            r_power <= n_power;
            r_lock  <= n_lock;
        end
    end

    assign o_result.motor_drive = drive;
    assign o_result.red_lamp    = (drive == DRIVE_UP);
    assign o_result.blue_lamp   = (drive == DRIVE_DOWN);
    assign o_result.powered     = n_power;
    assign o_result.locked      = n_lock;

endmodule

### hdl/power_window_controller.sv
// Power window controller top level: input and result registers around
// the mode state machine. Depends on pwc_pkg, pwc_cfg and pwc_fsm.
//
// Each accepted tick item yields exactly one result item. An item is
// captured into the input register, processed by the state machine once
// the result register is free or being emptied, and its result is
// registered into the result register, which drives o_out_valid. One item
// is taken every cycle while i_out_ready does not stall the output; the
// state machine updates the mode and counter as each item is processed.
// Configuration writes are always accepted (o_cfg_ready is tied high)
// and must be issued while no item is in flight.
module power_window_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pwc_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pwc_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pwc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pwc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pwc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      process;
    t_out_item result;
    t_cfg      cfg;

    pwc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pwc_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (process),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign process    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            if (process) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (process) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### sim/tb_power_window_controller.sv
`timescale 1ns / 1ps
// Testbench for power_window_controller: drives tick items and timing register writes,
// tracks the window state alongside the block and checks every result item.
// Depends on pwc_pkg and the power_window_controller RTL.
module tb_power_window_controller;
    import pwc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int IDLE_PCT       = 16;

    localparam logic [8:0] K_PWR = 9'h100;
    localparam logic [8:0] K_LCK = 9'h080;
    localparam logic [8:0] K_DU  = 9'h040;
    localparam logic [8:0] K_DD  = 9'h020;
    localparam logic [8:0] K_PU  = 9'h010;
    localparam logic [8:0] K_PD  = 9'h008;
    localparam logic [8:0] K_TOP = 9'h004;
    localparam logic [8:0] K_BOT = 9'h002;
    localparam logic [8:0] K_JAM = 9'h001;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [TICK_W-1:0] hold_cfg = REG_RESET;
    logic [TICK_W-1:0] reverse_cfg = REG_RESET;
    t_mode             win_mode = M_IDLE;
    logic [TICK_W-1:0] win_count = '0;
    logic              win_power = 1'b0;
    logic              win_lock = 1'b0;

    t_out_item drive_status_q[$];
    int        bad_fields = 0;
    bit        steady = 1'b0;
    int        holdoff_reqs = 0;
    int        holdoff_seen = 0;
    int        stall_left = 0;
    int        quiet_cycles = 0;

    power_window_controller uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void bump_count();
        if (win_count != 16'hFFFF)
            win_count = win_count + 16'd1;
    endfunction

    function automatic t_out_item window_tick(input t_in_item t);
        logic      up_req;
        logic      down_req;
        logic [1:0] drv;
        t_out_item r;
        drv = DRIVE_STOP;
        if (t.power_press) begin
            win_power = !win_power;
            if (!win_power) begin
                win_mode  = M_IDLE;
                win_count = '0;
            end
        end
        if (win_power && t.lock_press)
            win_lock = !win_lock;
        if (win_power) begin
            up_req   = t.driver_up || (t.passenger_up && !win_lock);
            down_req = t.driver_down || (t.passenger_down && !win_lock);
            case (win_mode)
                M_IDLE: begin
                    if (up_req) begin
                        win_mode  = M_UP_WAIT;
                        win_count = '0;
                    end else if (down_req) begin
                        win_mode  = M_DOWN_WAIT;
                        win_count = '0;
                    end
                end
                M_UP_WAIT: begin
                    if (t.jam_event) begin
                        win_mode  = M_REVERSE;
                        win_count = '0;
                    end else begin
                        bump_count();
                        if (win_count >= hold_cfg)
                            win_mode = up_req ? M_UP_MANUAL : M_UP_AUTO;
                    end
                end
                M_DOWN_WAIT: begin
                    bump_count();
                    if (win_count >= hold_cfg)
                        win_mode = down_req ? M_DOWN_MANUAL : M_DOWN_AUTO;
                end
                M_UP_MANUAL: begin
                    if (t.jam_event) begin
                        win_mode  = M_REVERSE;
                        win_count = '0;
                    end else if (!up_req) begin
                        win_mode = M_IDLE;
                    end
                end
                M_UP_AUTO: begin
                    if (t.jam_event) begin
                        win_mode  = M_REVERSE;
                        win_count = '0;
                    end else if (t.top_limit || down_req) begin
                        win_mode = M_IDLE;
                    end
                end
                M_DOWN_MANUAL: begin
                    if (!down_req)
                        win_mode = M_IDLE;
                end
                M_DOWN_AUTO: begin
                    if (t.bottom_limit || up_req)
                        win_mode = M_IDLE;
                end
                M_REVERSE: begin
                    if (win_count >= reverse_cfg)
                        win_mode = M_IDLE;
                end
                default: win_mode = M_IDLE;
            endcase
            case (win_mode)
                M_UP_MANUAL, M_UP_AUTO: begin
                    if (!t.top_limit)
                        drv = DRIVE_UP;
                end
                M_DOWN_MANUAL, M_DOWN_AUTO: begin
                    if (!t.bottom_limit)
                        drv = DRIVE_DOWN;
                end
                M_REVERSE: begin
                    drv = DRIVE_DOWN;
                    bump_count();
                end
                default: ;
            endcase
        end
        r.motor_drive = drv;
        r.red_lamp    = (drv == DRIVE_UP);
        r.blue_lamp   = (drv == DRIVE_DOWN);
        r.powered     = win_power;
        r.locked      = win_lock;
        return r;
    endfunction

    function automatic void match_field(input string field, input logic [1:0] want,
                                        input logic [1:0] got);
        if (got !== want) begin
            bad_fields++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (drive_status_q.size() == 0) begin
                bad_fields++;
                $display("%0t: unexpected item, expected none, actual %h", $time, out_item);
            end else begin
                want = drive_status_q.pop_front();
                match_field("motor_drive", want.motor_drive, out_item.motor_drive);
                match_field("red_lamp", {1'b0, want.red_lamp}, {1'b0, out_item.red_lamp});
                match_field("blue_lamp", {1'b0, want.blue_lamp}, {1'b0, out_item.blue_lamp});
                match_field("powered", {1'b0, want.powered}, {1'b0, out_item.powered});
                match_field("locked", {1'b0, want.locked}, {1'b0, out_item.locked});
            end
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end else if (holdoff_seen != holdoff_reqs) begin
            holdoff_seen = holdoff_reqs;
            stall_left   = HOLDOFF_CYCLES - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no item moved for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_tick(input logic [8:0] bits);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= t_in_item'(bits);
        do @(posedge i_clk); while (!in_ready);
        drive_status_q.push_back(window_tick(t_in_item'(bits)));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (drive_status_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_timing(input logic [TICK_W-1:0] hold, input logic [TICK_W-1:0] rev);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_HOLD_TICKS;
        cfg_data  <= hold;
        do @(posedge i_clk); while (!cfg_ready);
        hold_cfg = hold;
        cfg_index <= REG_REVERSE_TICKS;
        cfg_data  <= rev;
        do @(posedge i_clk); while (!cfg_ready);
        reverse_cfg = rev;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_gestures(input int n_items);
        int       sent;
        int       press_len;
        int       travel;
        int       btn;
        int       span;
        t_in_item it;
        sent = 0;
        span = (hold_cfg > 16'd20) ? 20 : int'(hold_cfg);
        while (sent < n_items) begin
            if ($urandom_range(99) < 12) begin
                repeat ($urandom_range(1, 6)) begin
                    send_tick(9'($urandom_range(511)));
                    sent++;
                end
            end else begin
                press_len = $urandom_range(1, 2 * span + 3);
                travel    = $urandom_range(1, 10);
                btn       = $urandom_range(3);
                for (int k = 0; k < press_len + travel; k++) begin
                    it = '0;
                    if (k == 0 && !win_power)
                        it.power_press = ($urandom_range(9) != 0);
                    else
                        it.power_press = ($urandom_range(99) == 0);
                    it.lock_press = ($urandom_range(99) < 3);
                    if (k < press_len) begin
                        case (btn)
                            0: it.driver_up = 1'b1;
                            1: it.driver_down = 1'b1;
                            2: it.passenger_up = 1'b1;
                            default: it.passenger_down = 1'b1;
                        endcase
                    end
                    if ($urandom_range(99) < 6) begin
                        case ($urandom_range(3))
                            0: it.driver_up = 1'b1;
                            1: it.driver_down = 1'b1;
                            2: it.passenger_up = 1'b1;
                            default: it.passenger_down = 1'b1;
                        endcase
                    end
                    it.top_limit    = ($urandom_range(99) < 7);
                    it.bottom_limit = ($urandom_range(99) < 7);
                    it.jam_event    = ($urandom_range(99) < 6);
                    send_tick(it);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_directed_travel();
        set_timing(16'd2, 16'd2);
        send_tick(K_DU);
        send_tick(K_LCK);
        send_tick(K_PWR | K_LCK);
        send_tick(K_PU);
        send_tick(K_LCK);
        send_tick(K_PU | K_DD);
        send_tick(K_PU);
        send_tick(K_PU);
        send_tick(K_PU | K_TOP);
        send_tick('0);
        send_tick(K_PD);
        send_tick('0);
        send_tick('0);
        send_tick(K_BOT);
        send_tick(K_DU);
        send_tick('0);
        send_tick('0);
        send_tick(K_JAM);
        send_tick(K_JAM);
        send_tick('0);
        send_tick('0);
        send_tick(K_DD | K_JAM);
        send_tick(K_PWR);
        send_tick(9'h1FF);
        send_tick(9'h1FF);
    endtask

    task automatic test_register_extremes();
        set_timing(16'd0, 16'd0);
        send_tick(K_DU);
        send_tick(K_DU);
        send_tick(K_JAM);
        send_tick('0);
        send_tick(K_DD);
        send_tick(K_DD);
        send_tick('0);
        set_timing(16'hFFFF, 16'hFFFF);
        send_tick(K_DU);
        send_tick(K_DU | K_JAM);
        send_tick('0);
        send_tick(K_PWR);
        send_tick(K_PWR | K_PD);
        send_tick(K_PD);
    endtask

    task automatic test_random_phases();
        set_timing(16'd1, 16'd1);
        run_gestures(320);
        set_timing(16'd3, 16'd4);
        steady = 1'b1;
        run_gestures(320);
        steady = 1'b0;
        set_timing(16'd5, 16'd2);
        run_gestures(320);
        set_timing(16'd10, 16'd8);
        run_gestures(320);
        set_timing(16'd1, 16'd20);
        run_gestures(320);
    endtask

    task automatic test_backpressure();
        set_timing(16'd2, 16'd3);
        steady = 1'b1;
        holdoff_reqs++;
        run_gestures(60);
        steady = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_travel();
        test_register_extremes();
        test_random_phases();
        test_backpressure();
        settle();
        repeat (8) @(posedge i_clk);
        if (bad_fields == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### power_window_controller.f
hdl/pwc_pkg.sv
hdl/pwc_cfg.sv
hdl/pwc_fsm.sv
hdl/power_window_controller.sv
sim/tb_power_window_controller.sv
